// ===== design/tsg_pkg.sv =====
// Package for the tracker sighting gate: state encoding, register indexes
// and the place-key constants. No dependencies.
package tsg_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PURGE,
    ST_LOOKUP,
    ST_VICTIM,
    ST_DIVIDE,
    ST_HASH,
    ST_KEYS,
    ST_WRITE,
    ST_OUT
  } state_e;

  localparam logic [1:0] REG_TTL      = 2'd0;
  localparam logic [1:0] REG_SEP      = 2'd1;
  localparam logic [1:0] REG_MIN_SEEN = 2'd2;
  localparam logic [1:0] REG_MIN_PLC  = 2'd3;

  localparam logic [31:0] HASH_LAT = 32'h9E3779B1;
  localparam logic [31:0] HASH_LON = 32'h85EBCA6B;
  localparam int unsigned STEP_NUM = 10000000;
  localparam int unsigned STEP_DEN = 111320;
  // Scaled reciprocal of STEP_DEN/STEP_NUM; the estimate is never more than one low.
  localparam int unsigned STEP_SHIFT = 17;
  localparam longint unsigned STEP_RECIP = ((64'd1 << STEP_SHIFT) * STEP_NUM) / STEP_DEN;
  localparam logic [15:0] SEP_FLOOR = 16'd5;
  localparam logic [15:0] STEP_FLOOR = 16'd50;
  localparam logic [15:0] SIGHT_MAX = 16'hFFFF;

endpackage

// ===== design/tracker_sighting_gate.sv =====
// Tracker sighting gate. One sighting in, one result out.
// Sighting counts, tracked entries and place records are kept in
// per-slot registers and one synchronous place-key memory.
// Usage:
//   Input channel: in_valid_i/in_stall_o with device_addr_i, lat_i,
//   longitude_i and now_ms_i. Output channel: out_valid_o/out_stall_i with
//   sighting_count_o, place_count_o and allow_emit_o. A transfer happens
//   when valid is high and stall is low.
//   One item at a time: each item walks the slot table one slot a cycle for
//   expiry, lookup and victim choice, runs a bit-serial divider for the two
//   grid cells, hashes them and reads the place list one key a cycle from the
//   memory. The result sits in the output register until taken; a stall there
//   only holds the result and the next item is taken when it leaves.
//   Reset clears all slot valid bits, the configuration registers and the
//   control state; the key memory is not cleared since only entries below a
//   slot's place count are compared.
//   Configuration writes are taken at any cycle through cfg_we_i.
module tracker_sighting_gate
  import tsg_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES    = 16,
  parameter int unsigned PLACES_PER_ENTRY = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [47:0]        device_addr_i,
  input  logic signed [30:0] lat_i,
  input  logic signed [31:0] longitude_i,
  input  logic [31:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        sighting_count_o,
  output logic [3:0]         place_count_o,
  output logic               allow_emit_o
);

  localparam int unsigned SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned PW = (PLACES_PER_ENTRY > 1) ? $clog2(PLACES_PER_ENTRY) : 1;
  localparam int unsigned CW = $clog2(PLACES_PER_ENTRY + 1);
  localparam int unsigned KD = TABLE_ENTRIES * PLACES_PER_ENTRY;
  localparam int unsigned KW = (KD > 1) ? $clog2(KD) : 1;
  localparam logic [SW:0] LAST_SLOT = (SW + 1)'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] PLACE_MAX = CW'(PLACES_PER_ENTRY);

  // Configuration registers.
  logic [15:0] ttl_q, sep_q, min_seen_q;
  logic [3:0]  min_plc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q      <= '0;
      sep_q      <= '0;
      min_seen_q <= '0;
      min_plc_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TTL:      ttl_q      <= cfg_data_i;
        REG_SEP:      sep_q      <= cfg_data_i;
        REG_MIN_SEEN: min_seen_q <= cfg_data_i;
        REG_MIN_PLC:  min_plc_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Slot table.
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [47:0] addr_q  [TABLE_ENTRIES];
  logic [31:0] time_q  [TABLE_ENTRIES];
  logic [15:0] seen_q  [TABLE_ENTRIES];
  logic [CW-1:0] pcnt_q [TABLE_ENTRIES];

  // Place-key memory.
  logic [31:0] key_mem [KD];
  logic [31:0] key_rd_q;
  logic        key_we;
  logic [KW-1:0] key_waddr, key_raddr;

  state_e state_q, state_d;

  logic [47:0] in_addr_q;
  logic signed [30:0] in_lat_q;
  logic signed [31:0] in_lon_q;
  logic [31:0] now_q;
  logic [SW:0] idx_q;
  logic [SW-1:0] slot_q;
  logic hit_q, free_q;
  logic [31:0] best_time_q;
  logic [31:0] ttl_ms_q;
  // Divider: unsigned magnitude over the grid step, both cells in parallel.
  logic [22:0] step_est_q, step_q;
  logic [31:0] lat_mag_q, lon_mag_q, lat_quo_q, lon_quo_q;
  logic [23:0] lat_rem_q, lon_rem_q;
  logic [5:0]  div_cnt_q;
  logic [31:0] hash_a_q, hash_b_q, key_q;
  logic [PW:0] kidx_q;
  logic        dup_q;
  logic [15:0] res_seen_q;
  logic [CW-1:0] res_pcnt_q;
  logic        out_valid_q;

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_waddr] <= key_q;
    key_rd_q <= key_mem[key_raddr];
  end

  // Grid step: a reciprocal multiply gives an estimate at most one low, and a
  // back-multiply check during the purge scan brings it to the exact quotient.
  logic [15:0] sep_fl;
  logic [39:0] step_num;
  logic [39:0] step_prod;
  logic [39:0] step_back;
  logic [39:0] step_rem;
  logic        step_inc;
  assign sep_fl    = (sep_q < SEP_FLOOR) ? SEP_FLOOR : sep_q;
  assign step_num  = 40'(sep_fl) * 40'(STEP_NUM);
  assign step_prod = 40'(sep_fl) * 40'(STEP_RECIP);
  assign step_back = 40'(step_est_q) * 40'(STEP_DEN);
  assign step_rem  = step_num - step_back;
  assign step_inc  = (step_rem >= 40'(STEP_DEN));

  logic [23:0] lat_trial, lon_trial;
  logic [SW-1:0] idx_s;
  logic [31:0] age;
  assign idx_s = idx_q[SW-1:0];
  assign age   = now_q - time_q[idx_s];
  assign lat_trial = {lat_rem_q[22:0], lat_mag_q[31]};
  assign lon_trial = {lon_rem_q[22:0], lon_mag_q[31]};

  assign key_raddr = KW'(slot_q) * KW'(PLACES_PER_ENTRY) + KW'(kidx_q[PW-1:0]);
  assign key_waddr = KW'(slot_q) * KW'(PLACES_PER_ENTRY) + KW'(pcnt_q[slot_q]);

  always_comb begin
    state_d = state_q;
    key_we  = 1'b0;
    case (state_q)
      ST_IDLE:   if (in_valid_i && !out_valid_q) state_d = ST_PURGE;
      ST_PURGE:  if (idx_q == LAST_SLOT) state_d = ST_LOOKUP;
      ST_LOOKUP: if (idx_q == LAST_SLOT) state_d = ST_VICTIM;
      ST_VICTIM: if (idx_q == LAST_SLOT) state_d = ST_DIVIDE;
      ST_DIVIDE: if (div_cnt_q == 6'd33) state_d = ST_HASH;
      ST_HASH:   state_d = ST_KEYS;
      ST_KEYS:   if (kidx_q == (PW + 1)'(pcnt_q[slot_q])) state_d = ST_WRITE;
      ST_WRITE: begin
        key_we  = !dup_q && (pcnt_q[slot_q] < PLACE_MAX);
        state_d = ST_OUT;
      end
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      div_cnt_q   <= '0;
      kidx_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          if (in_valid_i && !out_valid_q) begin
            in_addr_q  <= device_addr_i;
            in_lat_q   <= lat_i;
            in_lon_q   <= longitude_i;
            now_q      <= now_ms_i;
            ttl_ms_q   <= 32'(ttl_q) * 32'd1000;
            hit_q      <= 1'b0;
            free_q     <= 1'b0;
            step_est_q <= step_prod[STEP_SHIFT +: 23];
          end
        end
        ST_PURGE: begin
          if (idx_q == '0) step_q <= step_est_q + {22'd0, step_inc};
          if (ttl_ms_q != 0 && valid_q[idx_s] && age > ttl_ms_q) valid_q[idx_s] <= 1'b0;
          idx_q <= (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
        end
        ST_LOOKUP: begin
          if (idx_q == '0 && step_q < 23'(STEP_FLOOR)) step_q <= 23'(STEP_FLOOR);
          if (!hit_q && valid_q[idx_s] && addr_q[idx_s] == in_addr_q) begin
            hit_q <= 1'b1;
            slot_q <= idx_s;
          end else if (!hit_q && !free_q && !valid_q[idx_s]) begin
            free_q <= 1'b1;
            slot_q <= idx_s;
          end
          idx_q <= (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
        end
        ST_VICTIM: begin
          if (!hit_q && !free_q) begin
            if (idx_q == '0 || time_q[idx_s] < best_time_q) begin
              best_time_q <= time_q[idx_s];
              slot_q <= idx_s;
            end
          end
          idx_q <= (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
          if (idx_q == LAST_SLOT) div_cnt_q <= '0;
        end
        ST_DIVIDE: begin
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == 6'd0) begin
            if (!hit_q) begin
              valid_q[slot_q] <= 1'b1;
              addr_q[slot_q]  <= in_addr_q;
              seen_q[slot_q]  <= '0;
              pcnt_q[slot_q]  <= '0;
            end
            lat_mag_q <= in_lat_q[30] ? 32'(-33'(in_lat_q)) : 32'(in_lat_q);
            lon_mag_q <= in_lon_q[31] ? 32'(-33'(in_lon_q)) : 32'(in_lon_q);
            lat_rem_q <= '0;
            lon_rem_q <= '0;
          end else if (div_cnt_q <= 6'd32) begin
            if (lat_trial >= 24'(step_q)) begin
              lat_rem_q <= lat_trial - 24'(step_q);
              lat_quo_q <= {lat_quo_q[30:0], 1'b1};
            end else begin
              lat_rem_q <= lat_trial;
              lat_quo_q <= {lat_quo_q[30:0], 1'b0};
            end
            if (lon_trial >= 24'(step_q)) begin
              lon_rem_q <= lon_trial - 24'(step_q);
              lon_quo_q <= {lon_quo_q[30:0], 1'b1};
            end else begin
              lon_rem_q <= lon_trial;
              lon_quo_q <= {lon_quo_q[30:0], 1'b0};
            end
            lat_mag_q <= {lat_mag_q[30:0], 1'b0};
            lon_mag_q <= {lon_mag_q[30:0], 1'b0};
          end else begin
            time_q[slot_q] <= now_q;
            if (seen_q[slot_q] != SIGHT_MAX) seen_q[slot_q] <= seen_q[slot_q] + 1'b1;
          end
        end
        ST_HASH: begin
          hash_a_q <= (in_lat_q[30] ? -lat_quo_q : lat_quo_q) * HASH_LAT;
          hash_b_q <= (in_lon_q[31] ? -lon_quo_q : lon_quo_q) * HASH_LON;
          kidx_q <= '0;
          dup_q  <= 1'b0;
        end
        ST_KEYS: begin
          if (kidx_q == '0) key_q <= hash_a_q ^ hash_b_q;
          else if (key_rd_q == key_q) dup_q <= 1'b1;
          kidx_q <= kidx_q + 1'b1;
        end
        ST_WRITE: begin
          if (key_we) pcnt_q[slot_q] <= pcnt_q[slot_q] + 1'b1;
        end
        ST_OUT: begin
          res_seen_q  <= seen_q[slot_q];
          res_pcnt_q  <= pcnt_q[slot_q];
          out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE) || out_valid_q;
  assign out_valid_o      = out_valid_q;
  assign sighting_count_o = res_seen_q;
  assign place_count_o    = 4'(res_pcnt_q);
  assign allow_emit_o     = (res_seen_q >= min_seen_q) && (4'(res_pcnt_q) >= min_plc_q);

endmodule
